// ===== design/pbts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbts_pkg: shared constants for the priority bitmap thread scheduler
// command codes, field widths and parameter defaults
// ----------------------------------------------------------------------------
package pbts_pkg;

  // transaction field widths
  localparam int CMD_W   = 3;
  localparam int PRIO_W  = 6;
  localparam int TICKS_W = 32;

  // parameter defaults
  localparam int DEF_THREAD_SLOTS  = 32;
  localparam int DEF_TIMEOUT_WIDTH = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELAY   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READY   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UNREADY = 3'd4;

  // result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

endpackage

// ===== design/priority_bitmap_thread_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_bitmap_thread_scheduler
// bitmap thread scheduler with per-thread tick timeouts and priority pick
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | command, priority_req,
//          |           |                         | is_event_queue, ticks
//  out     | output    | out_valid_o/out_stall_i | next_thread, switch_needed,
//          |           |                         | status
//
//  start, delay, make ready and unready go through accept, then pick.
//  a tick uses one shared decrement/compare unit, which walks the timeout
//  memory one entry per cycle through its registered read.
//  reset clears the bitmaps and the current thread; the timeout memory has
//  no reset, and only entries written by a delay are ever decremented.
//  a result waiting under out_stall_i does not block the next transaction;
//  the pick step holds only when the previous result has not yet been taken.
// ----------------------------------------------------------------------------
module priority_bitmap_thread_scheduler #(
  parameter int THREAD_SLOTS  = pbts_pkg::DEF_THREAD_SLOTS,
  parameter int TIMEOUT_WIDTH = pbts_pkg::DEF_TIMEOUT_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pbts_pkg::CMD_W-1:0]   command_i,
  input  logic [pbts_pkg::PRIO_W-1:0]  priority_req_i,
  input  logic                         is_event_queue_i,
  input  logic [pbts_pkg::TICKS_W-1:0] ticks_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pbts_pkg::PRIO_W-1:0]  next_thread_o,
  output logic                         switch_needed_o,
  output logic                         status_o
);
  import pbts_pkg::*;

  localparam int IDX_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(THREAD_SLOTS - 1);
  localparam logic [TICKS_W-1:0] COUNT_MAX =
    TICKS_W'((64'd1 << TIMEOUT_WIDTH) - 64'd1);

  // sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TICK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_PICK  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [THREAD_SLOTS-1:0] ready_q, ready_d;
  logic [THREAD_SLOTS-1:0] delayed_q, delayed_d;
  logic [THREAD_SLOTS-1:0] evq_q, evq_d;
  logic [THREAD_SLOTS-1:0] reg_q, reg_d;
  logic [PRIO_W-1:0]       cur_q, cur_d;
  logic                    rej_q, rej_d;

  logic [IDX_W-1:0] walk_q, walk_d;
  logic [IDX_W-1:0] proc_idx_q;
  logic             proc_vld_q;

  logic [TIMEOUT_WIDTH-1:0] mem [THREAD_SLOTS];
  logic [TIMEOUT_WIDTH-1:0] rd_data_q;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [TIMEOUT_WIDTH-1:0] mem_wdata;

  logic              out_valid_q;
  logic [PRIO_W-1:0] next_q;
  logic              switch_q;
  logic              status_q;

  logic in_accept;
  logic out_taken;
  logic pick_fire;

  // decoded priorities
  logic [PRIO_W-1:0] prio_m1, cur_m1;
  logic [IDX_W-1:0]  prio_idx, cur_idx;
  logic              prio_ok, cur_ok;
  logic [THREAD_SLOTS-1:0] prio_bit, cur_bit;

  // shared decrement and zero-compare unit
  logic [TIMEOUT_WIDTH-1:0] dec_val;
  logic                     dec_zero;

  // highest-priority pick
  logic [THREAD_SLOTS-1:0] rev_ready, iso;
  logic [IDX_W-1:0]        iso_idx;
  logic [PRIO_W-1:0]       pick;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_taken = out_valid_q && !out_stall_i;
  assign pick_fire = (state_q == ST_PICK) && !(out_valid_q && out_stall_i);
  assign in_stall_o = (state_q != ST_IDLE);

  assign prio_m1  = priority_req_i - PRIO_W'(1);
  assign cur_m1   = cur_q - PRIO_W'(1);
  assign prio_idx = prio_m1[IDX_W-1:0];
  assign cur_idx  = cur_m1[IDX_W-1:0];
  assign prio_ok  = (priority_req_i != '0) &&
                    (priority_req_i <= PRIO_W'(THREAD_SLOTS));
  assign cur_ok   = (cur_q != '0) && (cur_q <= PRIO_W'(THREAD_SLOTS));
  assign prio_bit = prio_ok ? (THREAD_SLOTS'(1) << prio_idx) : '0;
  assign cur_bit  = cur_ok ? (THREAD_SLOTS'(1) << cur_idx) : '0;

  assign dec_val  = (rd_data_q != '0) ? (rd_data_q - TIMEOUT_WIDTH'(1)) : '0;
  assign dec_zero = (dec_val == '0);

  // isolate the top ready bit by reversing and keeping the lowest one
  always_comb begin
    for (int k = 0; k < THREAD_SLOTS; k++) begin
      rev_ready[k] = ready_q[THREAD_SLOTS-1-k];
    end
    iso = rev_ready & (~rev_ready + THREAD_SLOTS'(1));
    iso_idx = '0;
    for (int k = 0; k < THREAD_SLOTS; k++) begin
      if (iso[k]) begin
        iso_idx = iso_idx | IDX_W'(k);
      end
    end
    pick = (ready_q != '0) ? (PRIO_W'(THREAD_SLOTS) - PRIO_W'(iso_idx)) : '0;
  end

  // command decode, tick walk and sequencer
  always_comb begin
    state_d   = state_q;
    ready_d   = ready_q;
    delayed_d = delayed_q;
    evq_d     = evq_q;
    reg_d     = reg_q;
    cur_d     = cur_q;
    rej_d     = rej_q;
    walk_d    = walk_q;
    mem_we    = 1'b0;
    mem_waddr = cur_idx;
    mem_wdata = (ticks_i > COUNT_MAX) ? '1 : ticks_i[TIMEOUT_WIDTH-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          rej_d   = STATUS_OK;
          state_d = ST_PICK;
          case (command_i)
            CMD_TICK: begin
              walk_d  = '0;
              state_d = ST_TICK;
            end
            CMD_START: begin
              if (!prio_ok || ((reg_q & prio_bit) != '0)) begin
                rej_d = STATUS_REJECTED;
              end else begin
                reg_d   = reg_q | prio_bit;
                ready_d = ready_q | prio_bit;
                if (is_event_queue_i) begin
                  evq_d = evq_q | prio_bit;
                end
              end
            end
            CMD_DELAY: begin
              if (!cur_ok || ((evq_q & cur_bit) != '0) || (ticks_i == '0)) begin
                rej_d = STATUS_REJECTED;
              end else begin
                mem_we    = 1'b1;
                ready_d   = ready_q & ~cur_bit;
                delayed_d = delayed_q | cur_bit;
              end
            end
            CMD_READY: begin
              if (!prio_ok || ((reg_q & prio_bit) == '0) ||
                  ((evq_q & prio_bit) == '0)) begin
                rej_d = STATUS_REJECTED;
              end else begin
                ready_d = ready_q | prio_bit;
              end
            end
            CMD_UNREADY: begin
              if (!cur_ok || ((evq_q & cur_bit) == '0)) begin
                rej_d = STATUS_REJECTED;
              end else begin
                ready_d = ready_q & ~cur_bit;
              end
            end
            default: begin
              rej_d = STATUS_REJECTED;
            end
          endcase
        end
      end
      ST_TICK: begin
        if (walk_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end else begin
          walk_d = walk_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        if (pick_fire) begin
          cur_d   = pick;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // write back one decremented counter of a delayed thread
    if (proc_vld_q && delayed_q[proc_idx_q]) begin
      mem_we    = 1'b1;
      mem_waddr = proc_idx_q;
      mem_wdata = dec_val;
      if (dec_zero) begin
        ready_d[proc_idx_q]   = 1'b1;
        delayed_d[proc_idx_q] = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ready_q    <= '0;
      delayed_q  <= '0;
      evq_q      <= '0;
      reg_q      <= '0;
      cur_q      <= '0;
      rej_q      <= STATUS_OK;
      walk_q     <= '0;
      proc_vld_q <= 1'b0;
      proc_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      ready_q    <= ready_d;
      delayed_q  <= delayed_d;
      evq_q      <= evq_d;
      reg_q      <= reg_d;
      cur_q      <= cur_d;
      rej_q      <= rej_d;
      walk_q     <= walk_d;
      proc_vld_q <= (state_q == ST_TICK);
      proc_idx_q <= walk_q;
    end
  end

  // timeout memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_TICK) begin
      rd_data_q <= mem[walk_q];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pick_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_taken) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pick_fire) begin
      next_q   <= pick;
      switch_q <= (pick != cur_q);
      status_q <= rej_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign next_thread_o   = next_q;
  assign switch_needed_o = switch_q;
  assign status_o        = status_q;

  // a thread is never ready and delayed at once
  a_ready_delayed_disjoint: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (ready_q & delayed_q) == '0
  ) else $error("thread both ready and delayed");

  // only registered threads are ever runnable or waiting
  a_runnable_registered: assert property (
    @(posedge clk_i) disable iff (!rst_ni) ((ready_q | delayed_q) & ~reg_q) == '0
  ) else $error("unregistered thread in ready or delayed set");

  // a rejected transaction never asks for a switch
  a_reject_no_switch: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && status_q == STATUS_REJECTED) |-> !switch_q
  ) else $error("rejected transaction reports a switch");

  // non-tick transactions go straight to the pick step
  a_direct_pick: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (in_accept && command_i != CMD_TICK) |=> (state_q == ST_PICK)
  ) else $error("non-tick transaction did not go to pick");

  // a result never names a thread beyond the slot count
  a_pick_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q |-> (next_q <= PRIO_W'(THREAD_SLOTS))
  ) else $error("picked thread out of range");

endmodule
